// File: sv/nvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nvg_pkg;

    localparam int COORD_W   = 4;
    localparam int COUNT_W   = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    typedef struct packed {
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
        logic [COORD_W-1:0] target_z;
    } t_in;

    typedef struct packed {
        logic [COORD_W-1:0] grown_x;
        logic [COORD_W-1:0] grown_y;
        logic [COORD_W-1:0] grown_z;
        logic               target_already_marked;
        logic [COUNT_W-1:0] marked_total;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_LOOK,
        ST_CHECK
    } t_state;

endpackage
`default_nettype wire

// File: sv/nearest_voxel_grow_step.sv
// Nearest marked voxel search with one-step growth over a SIDE^3 occupancy
// memory (one bit per voxel, one read and one write port). After reset the
// block runs a clearing pass over all 2^(3*clog2(SIDE)) addresses
// (4096 at SIDE=16) with o_in_ready low, leaving only the centre voxel
// marked. Each accepted item is then scanned: the scan reads one occupancy
// bit per cycle through the single read port and a shared distance/compare
// unit tracks the best voxel; two more reads and one write finish the step.
// The next item is taken once the result is loaded into the output register,
// which holds it until taken. Target coordinates saturate to SIDE-1; grown
// coordinates keep their low four bits; the count saturates at 8191.
`timescale 1ns / 1ps
`default_nettype none
module nearest_voxel_grow_step #(
    parameter int SIDE = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  nvg_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output nvg_pkg::t_out  o_out_data
);
    import nvg_pkg::*;

    localparam int CW    = $clog2(SIDE);
    localparam int AW    = 3 * CW;
    localparam int DW    = 2 * CW + 2;
    localparam int DEPTH = 1 << AW;
    localparam logic [CW-1:0] LAST = CW'(SIDE - 1);
    localparam logic [CW-1:0] MID  = CW'(SIDE / 2);
    localparam logic [AW-1:0] CENTRE = {MID, MID, MID};

    function automatic logic [2*CW-1:0] sq_diff(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
        logic [CW-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return (2*CW)'(d) * (2*CW)'(d);
    endfunction

    function automatic logic [CW-1:0] step_to(input logic [CW-1:0] from,
                                              input logic [CW-1:0] to);
        if (to > from) return from + 1'b1;
        else if (to < from) return from - 1'b1;
        else return from;
    endfunction

    function automatic logic [CW-1:0] clamp(input logic [COORD_W-1:0] v);
        return (32'(v) > SIDE - 1) ? LAST : CW'(v);
    endfunction

    logic           r_mem [DEPTH];
    logic           r_rdata;

    t_state         r_state, n_state;
    logic [AW-1:0]  r_caddr;
    logic [CW-1:0]  r_tx, r_ty, r_tz;
    logic [CW-1:0]  r_sx, r_sy, r_sz;
    logic [CW-1:0]  r_px, r_py, r_pz;
    logic           r_pv;
    logic [CW-1:0]  r_bx, r_by, r_bz;
    logic [DW-1:0]  r_best;
    logic [CW-1:0]  r_nx, r_ny, r_nz;
    logic [COUNT_W-1:0] r_count;
    logic           r_ovalid;
    t_out           r_out;

    logic [AW-1:0]  rd_addr, wr_addr;
    logic           we, wd, chk_go, accept;
    logic [CW-1:0]  cx, cy, cz, sx, sy, sz;
    logic [DW-1:0]  cand_dist, cdist;
    logic           better;

    assign cx = clamp(i_in_data.target_x);
    assign cy = clamp(i_in_data.target_y);
    assign cz = clamp(i_in_data.target_z);
    assign cdist = DW'(sq_diff(MID, cx)) + DW'(sq_diff(MID, cy)) + DW'(sq_diff(MID, cz));

    assign cand_dist = DW'(sq_diff(r_px, r_tx)) + DW'(sq_diff(r_py, r_ty))
                     + DW'(sq_diff(r_pz, r_tz));
    assign better = r_pv && r_rdata && (cand_dist < r_best);

    assign sx = step_to(r_bx, r_tx);
    assign sy = step_to(r_by, r_ty);
    assign sz = step_to(r_bz, r_tz);

    assign chk_go = !r_ovalid || i_out_ready;
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        rd_addr    = {r_sx, r_sy, r_sz};
        wr_addr    = {r_nx, r_ny, r_nz};
        we         = 1'b0;
        wd         = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                wr_addr = r_caddr;
                we      = 1'b1;
                wd      = (r_caddr == CENTRE);
                if (r_caddr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_sx == LAST && r_sy == LAST && r_sz == LAST) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_LOOK;
            end
            ST_LOOK: begin
                rd_addr = {sx, sy, sz};
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                rd_addr = {r_nx, r_ny, r_nz};
                if (chk_go) begin
                    we      = !r_rdata;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (we) r_mem[wr_addr] <= wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caddr  <= '0;
            r_pv     <= 1'b0;
            r_count  <= COUNT_W'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_CLEAR) r_caddr <= r_caddr + 1'b1;
            r_pv <= (r_state == ST_SCAN);
            if (r_state == ST_CHECK && chk_go) begin
                r_ovalid <= 1'b1;
                if (!r_rdata && r_count != COUNT_MAX) r_count <= r_count + 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx   <= cx;
            r_ty   <= cy;
            r_tz   <= cz;
            r_sx   <= '0;
            r_sy   <= '0;
            r_sz   <= '0;
            r_bx   <= MID;
            r_by   <= MID;
            r_bz   <= MID;
            r_best <= cdist;
        end else begin
            if (r_state == ST_SCAN) begin
                if (r_sz == LAST) begin
                    r_sz <= '0;
                    if (r_sy == LAST) begin
                        r_sy <= '0;
                        r_sx <= r_sx + 1'b1;
                    end else begin
                        r_sy <= r_sy + 1'b1;
                    end
                end else begin
                    r_sz <= r_sz + 1'b1;
                end
            end
            if (better) begin
                r_best <= cand_dist;
                r_bx   <= r_px;
                r_by   <= r_py;
                r_bz   <= r_pz;
            end
        end
        r_px <= r_sx;
        r_py <= r_sy;
        r_pz <= r_sz;
        if (r_state == ST_LOOK) begin
            r_nx <= sx;
            r_ny <= sy;
            r_nz <= sz;
        end
        if (r_state == ST_CHECK && chk_go) begin
            r_out.grown_x               <= COORD_W'(r_nx);
            r_out.grown_y               <= COORD_W'(r_ny);
            r_out.grown_z               <= COORD_W'(r_nz);
            r_out.target_already_marked <= r_rdata;
            r_out.marked_total          <= (!r_rdata && r_count != COUNT_MAX)
                                           ? r_count + 1'b1 : r_count;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= $past(r_count))
        else $error("marked count decreased");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> r_state == ST_SCAN)
        else $error("accepted item did not start a scan");

    a_grow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && chk_go && !r_rdata)
        |=> (r_count == COUNT_MAX || r_count == $past(r_count) + 1'b1))
        else $error("new voxel not counted");

    a_best_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_DRAIN) |=> r_best <= $past(r_best))
        else $error("best distance grew during scan");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && r_ovalid && !i_out_ready) |=> r_state == ST_CHECK)
        else $error("result overwrote a pending item");

endmodule
`default_nettype wire

// File: dv/nearest_voxel_grow_step_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module nearest_voxel_grow_step_tb;
    import nvg_pkg::*;

    localparam int SIDE          = 16;
    localparam int CELLS         = SIDE * SIDE * SIDE;
    localparam int MID           = SIDE / 2;
    localparam int HOLD_CYCLES   = 10000;
    localparam int SETTLE_CYCLES = 4200;
    localparam int RECENT_DEPTH  = 6;

    typedef enum logic [1:0] {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FULL
    } t_pace;

    logic  i_clk     = 1'b0;
    logic  i_rst_n   = 1'b0;
    logic  in_valid  = 1'b0;
    logic  out_ready = 1'b0;
    t_in   in_data   = '0;
    logic  in_ready;
    logic  out_valid;
    t_out  out_data;

    t_pace pace = PACE_SLOW_SINK;
    t_in   pending_targets[$];
    t_in   recent_targets[$];
    t_out  expected_growth[$];
    bit    occupied[CELLS];
    logic [COUNT_W-1:0] occupied_count;
    int    hold_left = 0;
    bit    hold_done = 1'b0;
    int    fails     = 0;

    nearest_voxel_grow_step #(
        .SIDE (SIDE)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_out grow_toward(t_in tgt);
        int   tx, ty, tz, bx, by, bz, best, d, nx, ny, nz, idx;
        bit   hit;
        t_out res;
        tx = (tgt.target_x > SIDE - 1) ? SIDE - 1 : tgt.target_x;
        ty = (tgt.target_y > SIDE - 1) ? SIDE - 1 : tgt.target_y;
        tz = (tgt.target_z > SIDE - 1) ? SIDE - 1 : tgt.target_z;
        bx = MID;
        by = MID;
        bz = MID;
        best = (MID - tx) * (MID - tx) + (MID - ty) * (MID - ty) + (MID - tz) * (MID - tz);
        for (int x = 0; x < SIDE; x++) begin
            for (int y = 0; y < SIDE; y++) begin
                for (int z = 0; z < SIDE; z++) begin
                    if (occupied[(x * SIDE + y) * SIDE + z]) begin
                        d = (x - tx) * (x - tx) + (y - ty) * (y - ty) + (z - tz) * (z - tz);
                        if (d < best) begin
                            best = d;
                            bx = x;
                            by = y;
                            bz = z;
                        end
                    end
                end
            end
        end
        nx = bx + (tx > bx) - (tx < bx);
        ny = by + (ty > by) - (ty < by);
        nz = bz + (tz > bz) - (tz < bz);
        idx = (nx * SIDE + ny) * SIDE + nz;
        hit = occupied[idx];
        if (!hit) begin
            occupied[idx] = 1'b1;
            if (occupied_count < COUNT_MAX) occupied_count = occupied_count + 1'b1;
        end
        res.grown_x = nx[COORD_W-1:0];
        res.grown_y = ny[COORD_W-1:0];
        res.grown_z = nz[COORD_W-1:0];
        res.target_already_marked = hit;
        res.marked_total = occupied_count;
        return res;
    endfunction

    // driver: hold the item until taken, then predict and offer the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) expected_growth.push_back(grow_toward(in_data));
            if (pending_targets.size() != 0 && $urandom_range(99) >=
                    (pace == PACE_SLOW_SINK ? 34 : pace == PACE_SLOW_SOURCE ? 72 : 0)) begin
                in_valid <= 1'b1;
                in_data  <= pending_targets.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each item with the oldest expectation, pace the receiver
    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_growth.size() == 0) begin
                    $error("unexpected item: %p", out_data);
                    fails++;
                end else begin
                    want = expected_growth.pop_front();
                    if (out_data.grown_x !== want.grown_x) begin
                        $error("grown_x: expected %0d, actual %0d", want.grown_x, out_data.grown_x);
                        fails++;
                    end
                    if (out_data.grown_y !== want.grown_y) begin
                        $error("grown_y: expected %0d, actual %0d", want.grown_y, out_data.grown_y);
                        fails++;
                    end
                    if (out_data.grown_z !== want.grown_z) begin
                        $error("grown_z: expected %0d, actual %0d", want.grown_z, out_data.grown_z);
                        fails++;
                    end
                    if (out_data.target_already_marked !== want.target_already_marked) begin
                        $error("target_already_marked: expected %0d, actual %0d",
                               want.target_already_marked, out_data.target_already_marked);
                        fails++;
                    end
                    if (out_data.marked_total !== want.marked_total) begin
                        $error("marked_total: expected %0d, actual %0d",
                               want.marked_total, out_data.marked_total);
                        fails++;
                    end
                end
            end
            if (hold_left != 0) begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && pace == PACE_FULL && pending_targets.size() > 3) begin
                out_ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >=
                    (pace == PACE_SLOW_SINK ? 72 : pace == PACE_SLOW_SOURCE ? 34 : 0));
            end
        end
    end

    task automatic queue_target(int x, int y, int z);
        t_in tgt;
        tgt.target_x = x[COORD_W-1:0];
        tgt.target_y = y[COORD_W-1:0];
        tgt.target_z = z[COORD_W-1:0];
        pending_targets.push_back(tgt);
        recent_targets.push_back(tgt);
        if (recent_targets.size() > RECENT_DEPTH) void'(recent_targets.pop_front());
    endtask

    // mostly repeats and neighbours of recent targets, so chains reach them and hit
    task automatic queue_random(int n);
        int  pick;
        int  x, y, z;
        t_in old;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 45 || recent_targets.size() == 0) begin
                queue_target($urandom_range(15), $urandom_range(15), $urandom_range(15));
            end else begin
                old = recent_targets[$urandom_range(recent_targets.size() - 1)];
                x = old.target_x;
                y = old.target_y;
                z = old.target_z;
                if (pick >= 80) begin
                    x = x + $urandom_range(2) - 1;
                    y = y + $urandom_range(2) - 1;
                    z = z + $urandom_range(2) - 1;
                    x = (x < 0) ? 0 : (x > 15) ? 15 : x;
                    y = (y < 0) ? 0 : (y > 15) ? 15 : y;
                    z = (z < 0) ? 0 : (z > 15) ? 15 : z;
                end
                queue_target(x, y, z);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_targets.size() != 0 || in_valid || expected_growth.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++) occupied[i] = 1'b0;
        occupied[(MID * SIDE + MID) * SIDE + MID] = 1'b1;
        occupied_count = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_target(8, 8, 8);
        queue_target(0, 0, 0);
        queue_target(7, 7, 7);
        queue_target(15, 15, 15);
        queue_target(15, 0, 15);
        queue_target(0, 15, 0);
        queue_target(15, 0, 0);
        queue_target(0, 15, 15);
        queue_target(1, 2, 4);
        queue_target(8, 4, 2);
        queue_target(5, 10, 5);
        queue_target(10, 5, 10);
        queue_target(4, 8, 8);
        queue_target(12, 8, 8);
        queue_target(8, 8, 12);
        for (int i = 0; i < 8; i++) queue_target(0, 0, 0);
        queue_target(15, 15, 15);
        wait_drained();

        queue_random(39);
        wait_drained();
        pace = PACE_SLOW_SOURCE;
        queue_random(39);
        wait_drained();
        pace = PACE_FULL;
        queue_random(39);
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fails == 0 && expected_growth.size() == 0) begin
            $display("nearest_voxel_grow_step regression: pass");
        end else begin
            $display("nearest_voxel_grow_step regression: fail");
        end
        $finish;
    end

    initial begin
        #80000000;
        $display("nearest_voxel_grow_step regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
